/* rtl/ltpp_pkg.sv */
// ----------------------------------------------------------------------------
// ltpp_pkg: shared types and constants of the landscape test pattern pixel
// Coordinate widths, colour constants, sun geometry and the reciprocal
// multipliers that replace the constant divisions.
// ----------------------------------------------------------------------------
package ltpp_pkg;

  localparam int CoordW = 8;
  localparam int ChanW  = 8;

  // Numerators of the gradient divisions stay below 2^14.
  localparam int NumW   = 14;
  localparam int RecipW = 14;
  localparam int ProdW  = NumW + RecipW;
  localparam int RecipShift = 20;

  localparam logic [CoordW-1:0] HORIZON_ROW = 8'd88;

  // Sky numerators: 140y, 80y and 60y + 87 (the last gives a ceiling).
  localparam logic [NumW-1:0] SKY_R_MUL  = 14'd140;
  localparam logic [NumW-1:0] SKY_G_MUL  = 14'd80;
  localparam logic [NumW-1:0] SKY_B_MUL  = 14'd60;
  localparam logic [NumW-1:0] SKY_B_RND  = 14'd87;
  // Ground numerators: 40u, 30u + 71 (ceiling) and 15u.
  localparam logic [NumW-1:0] GND_R_MUL  = 14'd40;
  localparam logic [NumW-1:0] GND_G_MUL  = 14'd30;
  localparam logic [NumW-1:0] GND_G_RND  = 14'd71;
  localparam logic [NumW-1:0] GND_B_MUL  = 14'd15;

  // ceil(2^20 / 88) and ceil(2^20 / 72). Both overshoot 2^20 by 32 once
  // multiplied back, and n * 32 stays below 2^20 for every numerator that
  // can occur, so (n * M) >> 20 is the exact floor of the quotient.
  localparam logic [RecipW-1:0] RECIP_88  = 14'd11916;
  localparam logic [RecipW-1:0] RECIP_72  = 14'd14564;

  localparam logic [ChanW-1:0] SKY_R_BASE = 8'd70;
  localparam logic [ChanW-1:0] SKY_G_BASE = 8'd130;
  localparam logic [ChanW-1:0] SKY_B_BASE = 8'd220;
  localparam logic [ChanW-1:0] GND_R_BASE = 8'd50;
  localparam logic [ChanW-1:0] GND_G_BASE = 8'd100;
  localparam logic [ChanW-1:0] GND_B_BASE = 8'd30;

  // Sun centre in coordinates scaled by five.
  localparam int DeltaW = 11;
  localparam int SqW    = 21;
  localparam int DistW  = 22;
  localparam int GlowW  = 14;
  localparam logic [DeltaW-1:0] SUN_X5 = 11'd864;
  localparam logic [DeltaW-1:0] SUN_Y5 = 11'd176;
  localparam logic [DistW-1:0]  SUN_CORE_D = 22'd8100;
  localparam logic [DistW-1:0]  SUN_GLOW_D = 22'd16900;

  // ceil(2^20 / 110) and ceil(2^20 / 176); exact for a glow term up to 8800.
  // The divide by 880 is the divide by 110 followed by a shift of three.
  localparam logic [RecipW-1:0] RECIP_110 = 14'd9533;
  localparam logic [RecipW-1:0] RECIP_176 = 14'd5958;

  localparam logic [ChanW-1:0] CORE_R = 8'd255;
  localparam logic [ChanW-1:0] CORE_G = 8'd230;
  localparam logic [ChanW-1:0] CORE_B = 8'd80;
  localparam logic [ChanW-1:0] CHAN_MAX = 8'd255;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic             core;
    logic [ChanW-1:0] add_r;
    logic [ChanW-1:0] add_g;
    logic [ChanW-1:0] add_b;
  } sun_t;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

/* rtl/ltpp_in_if.sv */
// ----------------------------------------------------------------------------
// ltpp_in_if: coordinate channel
// Valid/ready channel that carries one pixel coordinate per item.
// ----------------------------------------------------------------------------
interface ltpp_in_if;
  logic                         valid;
  logic                         ready;
  logic [ltpp_pkg::CoordW-1:0]  column;
  logic [ltpp_pkg::CoordW-1:0]  row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

/* rtl/ltpp_out_if.sv */
// ----------------------------------------------------------------------------
// ltpp_out_if: colour channel
// Valid/ready channel that carries one pixel colour per item.
// ----------------------------------------------------------------------------
interface ltpp_out_if;
  logic                        valid;
  logic                        ready;
  logic [ltpp_pkg::ChanW-1:0]  red;
  logic [ltpp_pkg::ChanW-1:0]  green;
  logic [ltpp_pkg::ChanW-1:0]  blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* rtl/ltpp_grad.sv */
// ----------------------------------------------------------------------------
// ltpp_grad: sky and ground gradient
// Stage 1 forms the numerators, stage 2 divides by reciprocal multiplication,
// stage 3 applies the channel offsets and stage 4 aligns with the sun path.
// ----------------------------------------------------------------------------
module ltpp_grad (
  input  logic                         clk,
  input  ltpp_pkg::stage_en_t          en,
  input  logic [ltpp_pkg::CoordW-1:0]  row,
  output ltpp_pkg::rgb_t               base
);

  logic                         sky_s1_r, sky_s2_r;
  logic [ltpp_pkg::NumW-1:0]    nr_s1_r, ng_s1_r, nb_s1_r;
  logic [ltpp_pkg::RecipW-1:0]  recip_s1_r;
  logic [ltpp_pkg::ChanW-1:0]   qr_s2_r, qg_s2_r, qb_s2_r;
  ltpp_pkg::rgb_t               base_s3_r, base_s4_r;

  logic                         sky_nxt;
  logic [ltpp_pkg::NumW-1:0]    row_w, gnd_w;
  logic [ltpp_pkg::NumW-1:0]    nr_nxt, ng_nxt, nb_nxt;
  logic [ltpp_pkg::ProdW-1:0]   pr, pg, pb;
  ltpp_pkg::rgb_t               base_nxt;

  always_comb begin
    sky_nxt = row < ltpp_pkg::HORIZON_ROW;
    row_w   = ltpp_pkg::NumW'(row);
    gnd_w   = ltpp_pkg::NumW'(row - ltpp_pkg::HORIZON_ROW);
    if (sky_nxt) begin
      nr_nxt = row_w * ltpp_pkg::SKY_R_MUL;
      ng_nxt = row_w * ltpp_pkg::SKY_G_MUL;
      nb_nxt = row_w * ltpp_pkg::SKY_B_MUL + ltpp_pkg::SKY_B_RND;
    end else begin
      nr_nxt = gnd_w * ltpp_pkg::GND_R_MUL;
      ng_nxt = gnd_w * ltpp_pkg::GND_G_MUL + ltpp_pkg::GND_G_RND;
      nb_nxt = gnd_w * ltpp_pkg::GND_B_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      sky_s1_r   <= sky_nxt;
      nr_s1_r    <= nr_nxt;
      ng_s1_r    <= ng_nxt;
      nb_s1_r    <= nb_nxt;
      recip_s1_r <= sky_nxt ? ltpp_pkg::RECIP_88 : ltpp_pkg::RECIP_72;
    end
  end

  always_comb begin
    pr = ltpp_pkg::ProdW'(nr_s1_r) * ltpp_pkg::ProdW'(recip_s1_r);
    pg = ltpp_pkg::ProdW'(ng_s1_r) * ltpp_pkg::ProdW'(recip_s1_r);
    pb = ltpp_pkg::ProdW'(nb_s1_r) * ltpp_pkg::ProdW'(recip_s1_r);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      sky_s2_r <= sky_s1_r;
      qr_s2_r  <= pr[ltpp_pkg::RecipShift +: ltpp_pkg::ChanW];
      qg_s2_r  <= pg[ltpp_pkg::RecipShift +: ltpp_pkg::ChanW];
      qb_s2_r  <= pb[ltpp_pkg::RecipShift +: ltpp_pkg::ChanW];
    end
  end

  // No offset sum leaves the 8-bit range for any row.
  always_comb begin
    if (sky_s2_r) begin
      base_nxt.r = ltpp_pkg::SKY_R_BASE + qr_s2_r;
      base_nxt.g = ltpp_pkg::SKY_G_BASE + qg_s2_r;
      base_nxt.b = ltpp_pkg::SKY_B_BASE - qb_s2_r;
    end else begin
      base_nxt.r = ltpp_pkg::GND_R_BASE + qr_s2_r;
      base_nxt.g = ltpp_pkg::GND_G_BASE - qg_s2_r;
      base_nxt.b = ltpp_pkg::GND_B_BASE + qb_s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      base_s3_r <= base_nxt;
    end
    if (en.s4) begin
      base_s4_r <= base_s3_r;
    end
  end

  assign base = base_s4_r;

endmodule

/* rtl/ltpp_sun.sv */
// ----------------------------------------------------------------------------
// ltpp_sun: sun disc and glow
// Stage 1 forms the scaled distances, stage 2 squares them, stage 3 sums
// and classifies, stage 4 divides the glow term into per-channel boosts.
// ----------------------------------------------------------------------------
module ltpp_sun (
  input  logic                         clk,
  input  ltpp_pkg::stage_en_t          en,
  input  logic [ltpp_pkg::CoordW-1:0]  column,
  input  logic [ltpp_pkg::CoordW-1:0]  row,
  output ltpp_pkg::sun_t               sun
);

  localparam int SqProdW = 2 * ltpp_pkg::DeltaW;

  logic [ltpp_pkg::DeltaW-1:0]  adx_s1_r, ady_s1_r;
  logic [ltpp_pkg::SqW-1:0]     sqx_s2_r, sqy_s2_r;
  logic                         core_s3_r;
  logic [ltpp_pkg::GlowW-1:0]   glow_s3_r;
  ltpp_pkg::sun_t               sun_s4_r;

  logic [ltpp_pkg::DeltaW-1:0]  x5, y5, adx_nxt, ady_nxt;
  logic [SqProdW-1:0]           sqx, sqy;
  logic [ltpp_pkg::DistW-1:0]   dist_sq;
  logic [ltpp_pkg::DistW-1:0]   glow_full;
  logic [ltpp_pkg::GlowW-1:0]   glow_nxt;
  logic [ltpp_pkg::ProdW-1:0]   p110, p176;
  ltpp_pkg::sun_t               sun_nxt;

  // Absolute distances only: the squares do not need the sign.
  always_comb begin
    x5 = (ltpp_pkg::DeltaW'(column) << 2) + ltpp_pkg::DeltaW'(column);
    y5 = (ltpp_pkg::DeltaW'(row) << 2) + ltpp_pkg::DeltaW'(row);
    adx_nxt = (x5 >= ltpp_pkg::SUN_X5) ? x5 - ltpp_pkg::SUN_X5 : ltpp_pkg::SUN_X5 - x5;
    ady_nxt = (y5 >= ltpp_pkg::SUN_Y5) ? y5 - ltpp_pkg::SUN_Y5 : ltpp_pkg::SUN_Y5 - y5;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      adx_s1_r <= adx_nxt;
      ady_s1_r <= ady_nxt;
    end
  end

  always_comb begin
    sqx = SqProdW'(adx_s1_r) * SqProdW'(adx_s1_r);
    sqy = SqProdW'(ady_s1_r) * SqProdW'(ady_s1_r);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      sqx_s2_r <= sqx[ltpp_pkg::SqW-1:0];
      sqy_s2_r <= sqy[ltpp_pkg::SqW-1:0];
    end
  end

  // Outside the glow ring the boost term is zero, which leaves the base
  // colour untouched in the final stage.
  always_comb begin
    dist_sq   = ltpp_pkg::DistW'(sqx_s2_r) + ltpp_pkg::DistW'(sqy_s2_r);
    glow_full = ltpp_pkg::SUN_GLOW_D - dist_sq;
    glow_nxt  = (dist_sq < ltpp_pkg::SUN_GLOW_D) ? glow_full[ltpp_pkg::GlowW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      core_s3_r <= dist_sq < ltpp_pkg::SUN_CORE_D;
      glow_s3_r <= glow_nxt;
    end
  end

  always_comb begin
    p110 = ltpp_pkg::ProdW'(glow_s3_r) * ltpp_pkg::ProdW'(ltpp_pkg::RECIP_110);
    p176 = ltpp_pkg::ProdW'(glow_s3_r) * ltpp_pkg::ProdW'(ltpp_pkg::RECIP_176);
    sun_nxt.core  = core_s3_r;
    sun_nxt.add_r = p110[ltpp_pkg::RecipShift +: ltpp_pkg::ChanW];
    sun_nxt.add_g = p176[ltpp_pkg::RecipShift +: ltpp_pkg::ChanW];
    sun_nxt.add_b = sun_nxt.add_r >> 3;
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      sun_s4_r <= sun_nxt;
    end
  end

  assign sun = sun_s4_r;

endmodule

/* rtl/ltpp_blend.sv */
// ----------------------------------------------------------------------------
// ltpp_blend: colour blend and output register
// Adds the glow boost to the gradient colour with saturation, or paints the
// sun core, and holds the result for the output channel.
// ----------------------------------------------------------------------------
module ltpp_blend (
  input  logic                 clk,
  input  ltpp_pkg::stage_en_t  en,
  input  ltpp_pkg::rgb_t       base,
  input  ltpp_pkg::sun_t       sun,
  output ltpp_pkg::rgb_t       pixel
);

  localparam int SumW = ltpp_pkg::ChanW + 1;

  ltpp_pkg::rgb_t          pixel_r;
  ltpp_pkg::rgb_t          pixel_nxt;
  logic [SumW-1:0]         sum_r, sum_g, sum_b;

  function automatic logic [ltpp_pkg::ChanW-1:0] sat8(input logic [SumW-1:0] v);
    sat8 = v[SumW-1] ? ltpp_pkg::CHAN_MAX : v[ltpp_pkg::ChanW-1:0];
  endfunction

  always_comb begin
    sum_r = SumW'(base.r) + SumW'(sun.add_r);
    sum_g = SumW'(base.g) + SumW'(sun.add_g);
    sum_b = SumW'(base.b) + SumW'(sun.add_b);
    if (sun.core) begin
      pixel_nxt.r = ltpp_pkg::CORE_R;
      pixel_nxt.g = ltpp_pkg::CORE_G;
      pixel_nxt.b = ltpp_pkg::CORE_B;
    end else begin
      pixel_nxt.r = sat8(sum_r);
      pixel_nxt.g = sat8(sum_g);
      pixel_nxt.b = sat8(sum_b);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      pixel_r <= pixel_nxt;
    end
  end

  assign pixel = pixel_r;

endmodule

/* rtl/landscape_test_pattern_pixel.sv */
// ----------------------------------------------------------------------------
// landscape_test_pattern_pixel: landscape test pattern pixel generator
// Maps a pixel coordinate of a 240x160 frame to the colour of a sky and
// ground gradient with a sun disc and glow ring.
//
//   channel  direction  payload                    handshake
//   in_ch    sink       column[8], row[8]          valid/ready
//   out_ch   source     red[8], green[8], blue[8]  valid/ready
//
// Five register stages; the fifth is the output register. An item is taken
// every cycle unless a stall at the output has filled every stage, and its
// colour is presented from the output register once it has passed all five.
// Each stage has its own valid bit and loads when it is empty or when the
// stage after it moves, so a stall at the output fills bubbles first.
// Reset clears the valid bits only; payload registers keep their contents.
// ----------------------------------------------------------------------------
module landscape_test_pattern_pixel (
  input  logic         clk,
  input  logic         rst_n,
  ltpp_in_if.sink      in_ch,
  ltpp_out_if.source   out_ch
);

  localparam int Stages = 5;

  logic [Stages-1:0]    valid_r;
  logic [Stages-1:0]    load;
  ltpp_pkg::stage_en_t  en;
  ltpp_pkg::rgb_t       base;
  ltpp_pkg::sun_t       sun;
  ltpp_pkg::rgb_t       pixel;

  // load[i] is the enable of stage i + 1; the last stage waits on out_ch.
  always_comb begin
    load[Stages-1] = !valid_r[Stages-1] || out_ch.ready;
    for (int i = Stages - 2; i >= 0; i--) begin
      load[i] = !valid_r[i] || load[i+1];
    end
    en.s1 = load[0];
    en.s2 = load[1];
    en.s3 = load[2];
    en.s4 = load[3];
    en.s5 = load[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (load[0]) begin
        valid_r[0] <= in_ch.valid;
      end
      for (int i = 1; i < Stages; i++) begin
        if (load[i]) begin
          valid_r[i] <= valid_r[i-1];
        end
      end
    end
  end

  ltpp_grad u_grad (
    .clk  (clk),
    .en   (en),
    .row  (in_ch.row),
    .base (base)
  );

  ltpp_sun u_sun (
    .clk    (clk),
    .en     (en),
    .column (in_ch.column),
    .row    (in_ch.row),
    .sun    (sun)
  );

  ltpp_blend u_blend (
    .clk   (clk),
    .en    (en),
    .base  (base),
    .sun   (sun),
    .pixel (pixel)
  );

  assign in_ch.ready  = load[0];
  assign out_ch.valid = valid_r[Stages-1];
  assign out_ch.red   = pixel.r;
  assign out_ch.green = pixel.g;
  assign out_ch.blue  = pixel.b;

endmodule
